// ===== hw/rtl/ftpht_pkg.sv =====
// Shared constants, types and hash multiplier for the profiler hash table.
// No dependencies.
package ftpht_pkg;
    localparam int TABLE_SLOTS  = 1024;
    localparam int THREAD_COUNT = 16;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int THR_W    = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int ENTRIES  = TABLE_SLOTS * THREAD_COUNT;
    localparam int ADDR_W   = $clog2(ENTRIES);
    localparam int DEPTH_W  = 16;
    // key(64) depth(16) recursed(1) start(64) total(64)
    localparam int ENTRY_W  = 64 + DEPTH_W + 1 + 64 + 64;
    localparam int CNT_W    = SLOT_W + 1;

    localparam logic [63:0] HASH_MUL = 64'h2127599bf4325c37;
    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic CMD_ENTER = 1'b0;
    localparam logic CMD_EXIT  = 1'b1;

    typedef struct packed {
        logic [63:0]        key;
        logic [DEPTH_W-1:0] depth;
        logic               recursed;
        logic [63:0]        start;
        logic [63:0]        total;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic clr_step;   // write zero entry during clearing pass
        logic hash_lo;    // first partial product
        logic hash_hi;    // remaining partial products, set home slot
        logic rd;         // issue slot read
        logic adv;        // step to next slot (miss)
        logic wr;         // write updated entry
        logic cnt_upd;    // update per-thread counters
        logic emit;       // drive result
        logic [1:0] status;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic key_zero;
        logic cmd_exit;
        logic hit;
        logic empty;
        logic last_probe;
        logic clr_done;
    } t_sts;
endpackage

// ===== hw/rtl/ftpht_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ftpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/ftpht_datapath.sv =====
// Datapath: input capture, split hash multiply, slot RAM, counters, result.
// Depends on ftpht_pkg and ftpht_ram.
module ftpht_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ftpht_pkg::t_ctl       i_ctl,
    output ftpht_pkg::t_sts       o_sts,
    input  logic                  i_cmd,
    input  logic [3:0]            i_thread_index,
    input  logic [63:0]           i_func_address,
    input  logic [63:0]           i_timestamp,
    output logic [1:0]            o_status,
    output logic [9:0]            o_slot,
    output logic [63:0]           o_accumulated_ticks,
    output logic                  o_was_nested,
    output logic                  o_had_collision
);
    logic                           r_cmd;
    logic [ftpht_pkg::THR_W-1:0]    r_thr;
    logic [63:0]                    r_key, r_now, r_mix, r_plo;
    logic [ftpht_pkg::SLOT_W-1:0]   r_idx;
    logic [ftpht_pkg::CNT_W-1:0]    r_misses;
    logic [ftpht_pkg::ADDR_W-1:0]   r_clr;
    logic [63:0] r_probe_cnt [ftpht_pkg::THREAD_COUNT];
    logic [63:0] r_coll_cnt  [ftpht_pkg::THREAD_COUNT];

    logic [ftpht_pkg::ADDR_W-1:0] ram_addr;
    logic [ftpht_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic                          ram_we;
    ftpht_pkg::t_entry             cur, upd;
    logic [63:0]                   h1, mix_full, h3;
    logic [ftpht_pkg::THR_W-1:0]   thr_in;

    assign h1 = i_func_address ^ (i_func_address >> 23);
    // modulo THREAD_COUNT; power of two assumed for the index width
    assign thr_in = ftpht_pkg::THR_W'(32'(i_thread_index) % ftpht_pkg::THREAD_COUNT);

    // 64x64 low product split into 32-bit partials, the low partial registered first
    assign mix_full = r_plo
        + {(r_mix[31:0] * ftpht_pkg::HASH_MUL[63:32]), 32'd0}
        + {(r_mix[63:32] * ftpht_pkg::HASH_MUL[31:0]), 32'd0};
    assign h3 = mix_full ^ (mix_full >> 47);

    assign cur = ftpht_pkg::t_entry'(ram_rdata);

    always_comb begin
        upd = cur;
        if (cur.key == 64'd0) begin
            upd.key = r_key;
            upd.depth = '0;
            upd.recursed = 1'b0;
            upd.total = cur.total;
        end
        if (r_cmd == ftpht_pkg::CMD_ENTER) begin
            if (upd.depth == '0) begin
                upd.start = r_now;
            end else begin
                upd.recursed = 1'b1;
            end
            if (upd.depth != ftpht_pkg::DEPTH_MAX) begin
                upd.depth = upd.depth + 1'b1;
            end
        end else if (upd.depth != '0) begin
            upd.depth = upd.depth - 1'b1;
            if (upd.depth == '0) begin
                upd.total = cur.total + (r_now - cur.start);
            end
        end
    end

    always_comb begin
        ram_we    = i_ctl.clr_step | i_ctl.wr;
        ram_wdata = i_ctl.clr_step ? '0 : upd;
        ram_addr  = i_ctl.clr_step ? r_clr : {r_thr, r_idx};
    end

    ftpht_ram #(.WIDTH(ftpht_pkg::ENTRY_W), .DEPTH(ftpht_pkg::ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_sts.key_zero   = (r_key == 64'd0);
        o_sts.cmd_exit   = r_cmd;
        o_sts.hit        = (cur.key == r_key);
        o_sts.empty      = (cur.key == 64'd0);
        o_sts.last_probe = (r_misses == ftpht_pkg::CNT_W'(ftpht_pkg::TABLE_SLOTS - 1));
        o_sts.clr_done   = (r_clr == ftpht_pkg::ADDR_W'(ftpht_pkg::ENTRIES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            for (int t = 0; t < ftpht_pkg::THREAD_COUNT; t++) begin
                r_probe_cnt[t] <= '0;
                r_coll_cnt[t]  <= '0;
            end
            o_status <= ftpht_pkg::ST_OK;
        end else begin
            if (i_ctl.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            // a full table also counts the miss on the last slot probed
            if (i_ctl.cnt_upd && r_cmd == ftpht_pkg::CMD_ENTER && r_misses != '0) begin
                r_probe_cnt[r_thr] <= r_probe_cnt[r_thr] + 64'(r_misses) + 64'(i_ctl.adv);
                r_coll_cnt[r_thr]  <= r_coll_cnt[r_thr] + 64'd1;
            end
            if (i_ctl.emit) begin
                o_status <= i_ctl.status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_thr <= thr_in;
            r_key <= i_func_address;
            r_now <= i_timestamp;
            r_mix <= h1;
            r_misses <= '0;
        end
        if (i_ctl.hash_lo) begin
            r_plo <= r_mix[31:0] * ftpht_pkg::HASH_MUL[31:0];
        end
        if (i_ctl.hash_hi) begin
            r_idx <= h3[ftpht_pkg::SLOT_W-1:0];
        end
        if (i_ctl.adv) begin
            r_idx <= (r_idx == ftpht_pkg::SLOT_W'(ftpht_pkg::TABLE_SLOTS - 1))
                     ? '0 : r_idx + 1'b1;
            r_misses <= r_misses + 1'b1;
        end
        if (i_ctl.emit) begin
            if (i_ctl.status == ftpht_pkg::ST_OK) begin
                o_slot              <= 10'(r_idx);
                o_accumulated_ticks <= upd.total;
                o_was_nested        <= upd.recursed;
                o_had_collision     <= (r_misses != '0);
            end else begin
                o_slot              <= '0;
                o_accumulated_ticks <= '0;
                o_was_nested        <= 1'b0;
                o_had_collision     <= (i_ctl.status == ftpht_pkg::ST_FULL);
            end
        end
    end
endmodule

// ===== hw/rtl/ftpht_ctrl.sv =====
// Controller state machine: clearing pass, hash, probe loop, update, result.
// Depends on ftpht_pkg.
module ftpht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ftpht_pkg::t_sts i_sts,
    output ftpht_pkg::t_ctl o_ctl,
    output logic            o_busy,
    output logic            o_done
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_READ, S_CHECK
    } t_state;

    t_state r_state;

    always_comb begin
        o_ctl = '0;
        o_ctl.status = ftpht_pkg::ST_OK;
        case (r_state)
            S_CLEAR: o_ctl.clr_step = 1'b1;
            S_IDLE:  o_ctl.load = i_start;
            S_HASH1: begin
                if (i_sts.key_zero) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.status = ftpht_pkg::ST_NOT_FOUND;
                end else begin
                    o_ctl.hash_lo = 1'b1;
                end
            end
            S_HASH2: o_ctl.hash_hi = 1'b1;
            S_READ:  ;
            S_CHECK: begin
                if (i_sts.hit || (i_sts.empty && !i_sts.cmd_exit)) begin
                    o_ctl.wr = 1'b1;
                    o_ctl.cnt_upd = 1'b1;
                    o_ctl.emit = 1'b1;
                end else if (i_sts.empty) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.status = ftpht_pkg::ST_NOT_FOUND;
                end else if (i_sts.last_probe) begin
                    o_ctl.adv = 1'b1;
                    o_ctl.cnt_upd = 1'b1;
                    o_ctl.emit = 1'b1;
                    o_ctl.status = i_sts.cmd_exit ? ftpht_pkg::ST_NOT_FOUND
                                                  : ftpht_pkg::ST_FULL;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_busy  <= 1'b1;
            o_done  <= 1'b0;
        end else begin
            o_done <= o_ctl.emit;
            case (r_state)
                S_CLEAR: if (i_sts.clr_done) begin
                    r_state <= S_IDLE;
                    o_busy  <= 1'b0;
                end
                S_IDLE: if (i_start) begin
                    r_state <= S_HASH1;
                    o_busy  <= 1'b1;
                end
                S_HASH1: begin
                    r_state <= i_sts.key_zero ? S_IDLE : S_HASH2;
                    o_busy  <= ~i_sts.key_zero;
                end
                S_HASH2: r_state <= S_READ;
                S_READ:  r_state <= S_CHECK;
                S_CHECK: begin
                    if (o_ctl.emit) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/function_time_profiler_hash_table_unit.sv =====
// Per-thread function profiler hash table, linear probing, one result per beat.
// A zero address is answered from the first hash state; otherwise the hash is
// split over two multiply states, then each slot is read and checked via RAM.
// Throughput: one beat at a time; busy drops with o_done, so the next start
// can be taken at the edge that ends the o_done cycle.
// Reset: synchronous; a clearing pass over all 16384 entries, one per cycle,
// runs first with busy high. Results cannot be stalled.
module function_time_profiler_hash_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic        i_cmd,
    input  logic [3:0]  i_thread_index,
    input  logic [63:0] i_func_address,
    input  logic [63:0] i_timestamp,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [63:0] o_accumulated_ticks,
    output logic        o_was_nested,
    output logic        o_had_collision
);
    ftpht_pkg::t_ctl ctl;
    ftpht_pkg::t_sts sts;

    ftpht_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_ctl  (ctl),
        .o_busy (busy),
        .o_done (o_done)
    );

    ftpht_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cmd              (i_cmd),
        .i_thread_index     (i_thread_index),
        .i_func_address     (i_func_address),
        .i_timestamp        (i_timestamp),
        .o_status           (o_status),
        .o_slot             (o_slot),
        .o_accumulated_ticks(o_accumulated_ticks),
        .o_was_nested       (o_was_nested),
        .o_had_collision    (o_had_collision)
    );

    // a result always ends a busy period
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result without end of work");

    // an accepted beat makes the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat not tracked");

    // status is never the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3)) else $error("bad status");

    // error results carry no slot or time
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ftpht_pkg::ST_OK) |->
        (o_slot == '0 && o_accumulated_ticks == '0)) else $error("error fields set");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for function_time_profiler_hash_table_unit.
// Depends on ftpht_pkg (constants, status/cmd codes) and the unit RTL.
`timescale 1ns / 100ps

module tb_top;
    import ftpht_pkg::*;

    typedef struct {
        logic        cmd;
        logic [3:0]  thr;
        logic [63:0] addr;
        logic [63:0] ts;
    } t_event;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [63:0] ticks;
        logic        nested;
        logic        coll;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic        o_done;
    logic        i_cmd = 1'b0;
    logic [3:0]  i_thread_index = '0;
    logic [63:0] i_func_address = '0;
    logic [63:0] i_timestamp = '0;
    logic [1:0]  o_status;
    logic [9:0]  o_slot;
    logic [63:0] o_accumulated_ticks;
    logic        o_was_nested;
    logic        o_had_collision;

    function_time_profiler_hash_table_unit dut (.*);

    // shadow copy of the per-thread tables
    logic [63:0] tbl_key   [ENTRIES];
    logic [15:0] tbl_depth [ENTRIES];
    logic        tbl_rec   [ENTRIES];
    logic [63:0] tbl_start [ENTRIES];
    logic [63:0] tbl_total [ENTRIES];
    logic [63:0] probe_steps [THREAD_COUNT];
    logic [63:0] coll_lookups [THREAD_COUNT];

    t_event   pending_events[$];
    t_outcome expected_outcomes[$];
    t_event   cur;
    int       errors = 0;
    int       n_accepted = 0, n_checked = 0, n_full = 0, n_missing = 0, n_coll = 0;
    int       burst_left = 0, gap_left = 0;
    longint   cycles = 0;

    function automatic logic [63:0] fast_mix(input logic [63:0] a);
        logic [63:0] h;
        h = a ^ (a >> 23);
        h = h * HASH_MUL;
        h = h ^ (h >> 47);
        return h;
    endfunction

    function automatic t_outcome profile_event(input t_event ev);
        t_outcome r;
        int base, idx, e, misses;
        bit found, claimed;
        r = '{ST_NOT_FOUND, '0, '0, 1'b0, 1'b0};
        if (ev.addr == 0) return r;
        base = int'(ev.thr) * TABLE_SLOTS;
        idx = int'(fast_mix(ev.addr) % TABLE_SLOTS);
        misses = 0;
        found = 0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (tbl_key[base + idx] == ev.addr) begin
                found = 1;
                break;
            end
            if (tbl_key[base + idx] == 0) begin
                if (ev.cmd == CMD_ENTER) begin
                    tbl_key[base + idx] = ev.addr;
                    tbl_depth[base + idx] = '0;
                    tbl_rec[base + idx] = 1'b0;
                    found = 1;
                end
                break;
            end
            misses++;
            idx = (idx + 1 == TABLE_SLOTS) ? 0 : idx + 1;
        end
        if (ev.cmd == CMD_ENTER) begin
            probe_steps[ev.thr] += 64'(misses);
            if (misses > 0) coll_lookups[ev.thr] += 64'd1;
            if (!found) begin
                r.status = ST_FULL;
                r.coll = 1'b1;
                return r;
            end
            e = base + idx;
            if (tbl_depth[e] == 0) tbl_start[e] = ev.ts;
            else tbl_rec[e] = 1'b1;
            if (tbl_depth[e] != DEPTH_MAX) tbl_depth[e] = tbl_depth[e] + 16'd1;
        end else begin
            if (!found) return r;
            e = base + idx;
            if (tbl_depth[e] != 0) begin
                tbl_depth[e] = tbl_depth[e] - 16'd1;
                if (tbl_depth[e] == 0) tbl_total[e] = tbl_total[e] + (ev.ts - tbl_start[e]);
            end
        end
        r.status = ST_OK;
        r.slot = idx[9:0];
        r.ticks = tbl_total[e];
        r.nested = tbl_rec[e];
        r.coll = (misses > 0);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: one beat in flight, bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_outcomes.push_back(profile_event(cur));
                n_accepted++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    cur = pending_events.pop_front();
                    i_cmd <= cur.cmd;
                    i_thread_index <= cur.thr;
                    i_func_address <= cur.addr;
                    i_timestamp <= cur.ts;
                    start <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results cannot be stalled, check every strobe
    always @(posedge i_clk) begin
        t_outcome x;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result beat, status %0d", o_status);
                errors++;
            end else begin
                x = expected_outcomes.pop_front();
                n_checked++;
                if (x.status == ST_FULL) n_full++;
                if (x.status == ST_NOT_FOUND) n_missing++;
                if (x.coll) n_coll++;
                if (o_status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, o_status); errors++;
                end
                if (o_slot !== x.slot) begin
                    $error("slot exp %0d got %0d", x.slot, o_slot); errors++;
                end
                if (o_accumulated_ticks !== x.ticks) begin
                    $error("accumulated_ticks exp %h got %h", x.ticks, o_accumulated_ticks);
                    errors++;
                end
                if (o_was_nested !== x.nested) begin
                    $error("was_nested exp %b got %b", x.nested, o_was_nested); errors++;
                end
                if (o_had_collision !== x.coll) begin
                    $error("had_collision exp %b got %b", x.coll, o_had_collision); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd20000000) begin
            $display("timeout with %0d results outstanding", expected_outcomes.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_at_home(input int home);
        logic [63:0] k;
        do k = rand64(); while (k == 0 || int'(fast_mix(k) % TABLE_SLOTS) != home);
        return k;
    endfunction

    task automatic queue_event(input logic cmd, input int thr, input logic [63:0] addr,
                               input logic [63:0] ts);
        t_event ev;
        ev.cmd = cmd;
        ev.thr = thr[3:0];
        ev.addr = addr;
        ev.ts = ts;
        pending_events.push_back(ev);
    endtask

    initial begin
        logic [63:0] ka, kb, kc;
        logic [63:0] pool [16][8];
        logic [63:0] clock_of [16];
        logic [63:0] call_stack [16][$];
        int t, r, k;

        for (int i = 0; i < ENTRIES; i++) begin
            tbl_key[i] = '0; tbl_depth[i] = '0; tbl_rec[i] = 1'b0;
            tbl_start[i] = '0; tbl_total[i] = '0;
        end
        for (int i = 0; i < THREAD_COUNT; i++) begin
            probe_steps[i] = '0; coll_lookups[i] = '0;
        end

        // directed: wrap past the last slot, zero address, unbalanced exit,
        // recursion, missing key, extreme address and timestamps
        ka = key_at_home(TABLE_SLOTS - 1);
        kb = key_at_home(TABLE_SLOTS - 1);
        kc = key_at_home(0);
        queue_event(CMD_ENTER, 3, ka, 64'd100);
        queue_event(CMD_ENTER, 3, kb, 64'd150);
        queue_event(CMD_ENTER, 3, kc, 64'd160);
        queue_event(CMD_EXIT, 3, kb, 64'd400);
        queue_event(CMD_EXIT, 3, kc, 64'd401);
        queue_event(CMD_EXIT, 3, kc, 64'd500);
        queue_event(CMD_ENTER, 3, ka, 64'd600);
        queue_event(CMD_EXIT, 3, ka, 64'd700);
        queue_event(CMD_EXIT, 3, ka, 64'd900);
        queue_event(CMD_ENTER, 0, '0, '1);
        queue_event(CMD_EXIT, 15, '0, '0);
        queue_event(CMD_EXIT, 0, 64'h1234_5678_9abc_def0, 64'd5);
        queue_event(CMD_ENTER, 15, '1, '1);
        queue_event(CMD_EXIT, 15, '1, 64'd3);
        queue_event(CMD_ENTER, 8, 64'd1, '0);
        queue_event(CMD_ENTER, 8, 64'd1, 64'd10);
        queue_event(CMD_EXIT, 8, 64'd1, 64'd20);
        queue_event(CMD_EXIT, 8, 64'd1, 64'h8000_0000_0000_0000);

        // fill one thread, then a full enter and an exhaustive missing-key exit
        for (int i = 0; i < TABLE_SLOTS; i++)
            queue_event(CMD_ENTER, 7, rand64() | 64'd1, rand64());
        queue_event(CMD_ENTER, 7, 64'hdead_beef_0000_0001, 64'd1);
        queue_event(CMD_EXIT, 7, 64'hdead_beef_0000_0001, 64'd2);

        // deep nesting on one key
        ka = rand64() | 64'd2;
        for (int i = 0; i < 8; i++)
            queue_event(CMD_ENTER, 5, ka, 64'd1000 + i);
        queue_event(CMD_EXIT, 5, ka, 64'd99999);

        // random call trees, colliding keys in each pool, some noise
        for (int i = 0; i < 16; i++) begin
            pool[i][0] = key_at_home($urandom_range(0, TABLE_SLOTS - 1));
            for (int j = 1; j < 8; j++)
                pool[i][j] = (j < 4) ? key_at_home(int'(fast_mix(pool[i][0]) % TABLE_SLOTS))
                                     : (rand64() | 64'd1);
            clock_of[i] = rand64();
        end
        for (int n = 0; n < 650; n++) begin
            do t = $urandom_range(0, 15); while (t == 7);
            clock_of[t] += $urandom_range(1, 5000);
            r = $urandom_range(0, 99);
            if (r < 45 && call_stack[t].size() < 6) begin
                k = $urandom_range(0, 7);
                call_stack[t].push_back(pool[t][k]);
                queue_event(CMD_ENTER, t, pool[t][k], clock_of[t]);
            end else if (r < 88 && call_stack[t].size() > 0) begin
                queue_event(CMD_EXIT, t, call_stack[t].pop_back(), clock_of[t]);
            end else if (r < 92) begin
                queue_event(1'($urandom_range(0, 1)), t, '0, rand64());
            end else if (r < 96) begin
                queue_event(CMD_EXIT, t, rand64() | 64'd1, rand64());
            end else begin
                queue_event(1'($urandom_range(0, 1)), t, pool[t][$urandom_range(0, 7)],
                            rand64());
            end
        end

        wait (i_rst_n === 1'b1);
        while (pending_events.size() > 0 || start) @(posedge i_clk);
        while (expected_outcomes.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("%0d beats accepted, %0d results checked", n_accepted, n_checked);
        $display("%0d table-full, %0d not-found, %0d with collision", n_full, n_missing, n_coll);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
